[rtl/core/edge_timestamp_uart_receiver_core_assert.svh]
// Assertion macros for the edge timestamp serial receiver.
`ifndef EDGE_TIMESTAMP_UART_RECEIVER_CORE_ASSERT_SVH
`define EDGE_TIMESTAMP_UART_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTH

`define ETS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`define ETS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`else

`define ETS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ETS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/core/ets_pkg.sv]
`timescale 1ns / 1ps

package ets_pkg;

   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned PeriodWidth  = 16;
   localparam int unsigned TimeoutWidth = 20;
   localparam int unsigned CsrDataWidth = 20;
   localparam int unsigned CountWidth   = 4;

   localparam logic [PeriodWidth-1:0]  PeriodReset  = 16'd100;
   localparam logic [TimeoutWidth-1:0] TimeoutReset = 20'd1000;
   // start bit plus eight data bits plus stop bit
   localparam logic [CountWidth-1:0]   FrameBits    = 4'd10;

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   typedef enum logic {
      CSR_BIT_PERIOD    = 1'b0,
      CSR_FRAME_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                 borrow;
      logic [TimeWidth-1:0] diff;
   } sub_res_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       ended_by_timeout;
   } emit_type;

   typedef struct packed {
      logic                  idle;
      logic                  armed;
      logic [CountWidth-1:0] frame_bit_count;
   } status_type;

endpackage

[rtl/core/ets_sub.sv]
`timescale 1ns / 1ps

// Shared 32-bit subtractor; borrow set when op_a < op_b.
module ets_sub (
   input  logic [ets_pkg::TimeWidth-1:0] op_a,
   input  logic [ets_pkg::TimeWidth-1:0] op_b,
   output ets_pkg::sub_res_type          res
);

   logic [ets_pkg::TimeWidth:0] full;

   assign full = {1'b0, op_a} - {1'b0, op_b};
   assign res.borrow = full[ets_pkg::TimeWidth];
   assign res.diff   = full[ets_pkg::TimeWidth-1:0];

endmodule

[rtl/core/ets_seq.sv]
`timescale 1ns / 1ps

module ets_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [0:0]                       csr_index,
   input  logic [ets_pkg::CsrDataWidth-1:0] csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [ets_pkg::TimeWidth-1:0]    req_time_us,
   input  logic                             req_line_level,
   output ets_pkg::emit_type                emit,
   input  logic                             emit_ready,
   output ets_pkg::status_type              stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_NEG,
      S_SHIFT,
      S_TCHK,
      S_TCMP,
      S_FILL,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [ets_pkg::PeriodWidth-1:0]  period_ff, period_in;
   logic [ets_pkg::TimeoutWidth-1:0] timeout_ff, timeout_in;
   logic [ets_pkg::CountWidth-1:0]   count_ff, count_in;
   logic                             armed_ff, armed_in;
   logic [7:0]                       shift_value_ff, shift_value_in;
   logic [ets_pkg::TimeWidth-1:0]    last_ff, last_in;
   logic [ets_pkg::TimeWidth-1:0]    start_ff, start_in;
   logic [ets_pkg::TimeWidth-1:0]    now_ff, now_in;
   logic                             level_ff, level_in;
   logic [ets_pkg::TimeWidth-1:0]    gap_ff, gap_in;
   logic                             tmo_ff, tmo_in;

   logic [ets_pkg::TimeWidth-1:0]  op_a, op_b;
   ets_pkg::sub_res_type           sub_res;
   logic [ets_pkg::CountWidth-1:0] count_inc;

   ets_sub u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .res  (sub_res)
   );

   assign count_inc = count_ff + 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   assign emit.valid            = (state_ff == S_EMIT);
   assign emit.data_byte        = shift_value_ff;
   assign emit.ended_by_timeout = tmo_ff;

   assign stat.idle            = (state_ff == S_IDLE);
   assign stat.armed           = armed_ff;
   assign stat.frame_bit_count = count_ff;

   always_comb begin
      unique case (state_ff)
         S_DIFF: begin
            op_a = now_ff;
            op_b = last_ff;
         end
         S_NEG: begin
            op_a = last_ff;
            op_b = now_ff;
         end
         S_TCHK: begin
            op_a = now_ff;
            op_b = start_ff;
         end
         S_TCMP: begin
            op_a = gap_ff;
            op_b = {{(ets_pkg::TimeWidth-ets_pkg::TimeoutWidth){1'b0}}, timeout_ff};
         end
         default: begin
            op_a = gap_ff;
            op_b = {{(ets_pkg::TimeWidth-ets_pkg::PeriodWidth){1'b0}}, period_ff};
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      period_in      = period_ff;
      timeout_in     = timeout_ff;
      count_in       = count_ff;
      armed_in       = armed_ff;
      shift_value_in = shift_value_ff;
      last_in        = last_ff;
      start_in       = start_ff;
      now_in         = now_ff;
      level_in       = level_ff;
      gap_in         = gap_ff;
      tmo_in         = tmo_ff;

      if (csr_write_en) begin
         unique case (ets_pkg::csr_index_type'(csr_index))
            ets_pkg::CSR_BIT_PERIOD:
               period_in = csr_write_data[ets_pkg::PeriodWidth-1:0];
            ets_pkg::CSR_FRAME_TIMEOUT:
               timeout_in = csr_write_data[ets_pkg::TimeoutWidth-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in   = req_time_us;
               level_in = req_line_level;
               if (ets_pkg::command_type'(req_command) == ets_pkg::CMD_TICK) begin
                  if (armed_ff) state_in = S_TCHK;
               end else if (count_ff == '0) begin
                  // low edge while idle is a start bit
                  if (!req_line_level) begin
                     last_in        = req_time_us;
                     start_in       = req_time_us;
                     count_in       = {{(ets_pkg::CountWidth-1){1'b0}}, 1'b1};
                     shift_value_in = '0;
                     armed_in       = 1'b1;
                  end
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            if (sub_res.borrow) begin
               state_in = S_NEG;
            end else begin
               gap_in   = sub_res.diff;
               state_in = S_SHIFT;
            end
         end
         S_NEG: begin
            gap_in   = sub_res.diff;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // one whole bit period per cycle; remainder dropped
            if (sub_res.borrow) begin
               last_in  = now_ff;
               state_in = S_IDLE;
            end else begin
               shift_value_in = {~level_ff, shift_value_ff[7:1]};
               count_in       = count_inc;
               gap_in         = sub_res.diff;
               if (count_inc == ets_pkg::FrameBits) begin
                  count_in = '0;
                  armed_in = 1'b0;
                  tmo_in   = 1'b0;
                  state_in = S_EMIT;
               end
            end
         end
         S_TCHK: begin
            gap_in   = sub_res.diff;
            state_in = S_TCMP;
         end
         S_TCMP: begin
            if (sub_res.borrow) begin
               state_in = S_IDLE;
            end else begin
               armed_in = 1'b0;
               if (!level_ff) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            shift_value_in = {1'b1, shift_value_ff[7:1]};
            count_in       = count_inc;
            if (count_inc == ets_pkg::FrameBits) begin
               count_in = '0;
               tmo_in   = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_ready) state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         period_ff  <= ets_pkg::PeriodReset;
         timeout_ff <= ets_pkg::TimeoutReset;
         count_ff   <= '0;
         armed_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         period_ff  <= period_in;
         timeout_ff <= timeout_in;
         count_ff   <= count_in;
         armed_ff   <= armed_in;
      end
      shift_value_ff <= shift_value_in;
      last_ff        <= last_in;
      start_ff       <= start_in;
      now_ff         <= now_in;
      level_ff       <= level_in;
      gap_ff         <= gap_in;
      tmo_ff         <= tmo_in;
   end

endmodule

[rtl/core/edge_timestamp_uart_receiver_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// req       req_valid/req_ready    req_command, req_time_us, req_line_level
// rsp       rsp_valid/rsp_ready    rsp_data_byte, rsp_ended_by_timeout
// csr       csr_write_en           csr_index, csr_write_data
//
// Start edges, ignored edges and ticks with no frame open are handled in S_IDLE.
// Other edges: S_DIFF, and S_NEG for an earlier stamp, form the absolute gap;
// then S_SHIFT takes off whole bit periods one by one via the shared subtractor.
// Ticks on an open frame: S_TCHK and S_TCMP compare the timeout; an expired tick
// with the line high fills bits in S_FILL, then S_EMIT hands over the byte.
// Reset is synchronous and clears control state. A result waits in the
// output register; the sequencer holds its finished byte while that is full and unread.

module edge_timestamp_uart_receiver_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [0:0]                       csr_index,
   input  logic [ets_pkg::CsrDataWidth-1:0] csr_write_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [ets_pkg::TimeWidth-1:0]    req_time_us,
   input  logic                             req_line_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_data_byte,
   output logic                             rsp_ended_by_timeout
);

   `include "edge_timestamp_uart_receiver_core_assert.svh"

   ets_pkg::emit_type   emit;
   ets_pkg::status_type stat;
   logic                emit_ready;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_tmo_ff, rsp_tmo_in;

   ets_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_time_us    (req_time_us),
      .req_line_level (req_line_level),
      .emit           (emit),
      .emit_ready     (emit_ready),
      .stat           (stat)
   );

   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_tmo_in   = rsp_tmo_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (emit.valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data_byte;
         rsp_tmo_in   = emit.ended_by_timeout;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_tmo_ff  <= rsp_tmo_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data_byte        = rsp_data_ff;
   assign rsp_ended_by_timeout = rsp_tmo_ff;

   // bit count wraps to zero on the tenth frame bit
   `ETS_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1,
                     stat.frame_bit_count < ets_pkg::FrameBits)
   // between items, a frame is open exactly when the timeout is armed
   `ETS_ASSERT_IMPLY(a_armed_open, clock, reset, stat.idle,
                     stat.armed == (stat.frame_bit_count != '0))
   // a finished byte is only offered while busy and lands in the output stage
   `ETS_ASSERT_IMPLY(a_emit_busy, clock, reset, emit.valid, !req_ready)
   `ETS_ASSERT_NEXT(a_emit_lands, clock, reset, emit.valid && emit_ready,
                    rsp_valid && stat.idle)

endmodule

[dv/edge_timestamp_uart_receiver_core_tb.sv]
`timescale 1ns / 1ps

module edge_timestamp_uart_receiver_core_tb;

   localparam int IdlePercent = 35;
   localparam int DrainCycles = 30;
   localparam int CycleLimit  = 400000;
   localparam int MaxPrinted  = 50;

   typedef struct packed {
      logic [7:0] data;
      logic       by_timeout;
   } serial_byte_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_en;
   logic [0:0]                       csr_index;
   logic [ets_pkg::CsrDataWidth-1:0] csr_write_data;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_command;
   logic [ets_pkg::TimeWidth-1:0]    req_time_us;
   logic                             req_line_level;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_data_byte;
   logic                             rsp_ended_by_timeout;

   // receiver model state and its copy of the registers
   logic [ets_pkg::PeriodWidth-1:0]  rx_period;
   logic [ets_pkg::TimeoutWidth-1:0] rx_timeout;
   logic [ets_pkg::CountWidth-1:0]   rx_bit_count;
   logic [7:0]                       rx_shift;
   logic [ets_pkg::TimeWidth-1:0]    rx_last_edge;
   logic [ets_pkg::TimeWidth-1:0]    rx_start;
   logic                             rx_armed;

   serial_byte_type pending_bytes[$];
   int              error_count;
   int              items_sent;
   int              bytes_checked;
   int              csr_writes;
   int              ready_hold;
   bit              idle_on;

   edge_timestamp_uart_receiver_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_time_us          (req_time_us),
      .req_line_level       (req_line_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_ended_by_timeout (rsp_ended_by_timeout)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("edge_timestamp_uart_receiver_core verification failed");
      $finish;
   end

   function automatic void reset_receiver_model();
      rx_period    = ets_pkg::PeriodReset;
      rx_timeout   = ets_pkg::TimeoutReset;
      rx_bit_count = '0;
      rx_shift     = '0;
      rx_last_edge = '0;
      rx_start     = '0;
      rx_armed     = 1'b0;
   endfunction

   function automatic void shift_in_bit(input logic b);
      rx_shift     = {b, rx_shift[7:1]};
      rx_bit_count = rx_bit_count + 1'b1;
   endfunction

   // returns 1 when the event closes a frame, with the byte in data
   function automatic bit decode_event(input logic cmd,
                                       input logic [ets_pkg::TimeWidth-1:0] stamp,
                                       input logic lvl, output logic [7:0] data,
                                       output logic by_timeout);
      logic [ets_pkg::TimeWidth-1:0] gap;
      data       = '0;
      by_timeout = 1'b0;
      if (cmd == ets_pkg::CMD_TICK) begin
         if (!rx_armed || (stamp - rx_start) < 32'(rx_timeout))
            return 1'b0;
         rx_armed = 1'b0;
         if (!lvl) begin
            rx_bit_count = '0;
            return 1'b0;
         end
         while (rx_bit_count < ets_pkg::FrameBits)
            shift_in_bit(1'b1);
         rx_bit_count = '0;
         data       = rx_shift;
         by_timeout = 1'b1;
         return 1'b1;
      end
      if (rx_bit_count == '0) begin
         if (!lvl) begin
            rx_last_edge = stamp;
            rx_start     = stamp;
            rx_bit_count = 4'd1;
            rx_shift     = '0;
            rx_armed     = 1'b1;
         end
         return 1'b0;
      end
      gap = (stamp > rx_last_edge) ? stamp - rx_last_edge : rx_last_edge - stamp;
      // zero period never ends this loop by the gap; the frame count does
      while (gap >= 32'(rx_period)) begin
         shift_in_bit(~lvl);
         if (rx_bit_count >= ets_pkg::FrameBits) begin
            rx_armed     = 1'b0;
            rx_bit_count = '0;
            data         = rx_shift;
            return 1'b1;
         end
         gap = gap - 32'(rx_period);
      end
      rx_last_edge = stamp;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MaxPrinted)
         $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // entered and left at a falling edge
   task automatic send_item(input ets_pkg::command_type cmd,
                            input logic [ets_pkg::TimeWidth-1:0] stamp,
                            input logic lvl);
      logic [7:0] data;
      logic       by_to;
      while (idle_on && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_time_us    <= stamp;
      req_line_level <= lvl;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (decode_event(cmd, stamp, lvl, data, by_to))
         pending_bytes.push_back('{data, by_to});
      @(negedge clock);
   endtask

   task automatic write_register(input ets_pkg::csr_index_type idx,
                                 input logic [19:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      if (idx == ets_pkg::CSR_BIT_PERIOD)
         rx_period = value[ets_pkg::PeriodWidth-1:0];
      else
         rx_timeout = value;
      csr_writes++;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(negedge clock);
      // edges that yield nothing may still be in the subtractor
      repeat (DrainCycles) @(negedge clock);
   endtask

   // line levels: start bit, data LSB first, stop bit; an edge only on a change
   task automatic send_frame(input logic [7:0] data,
                             input logic [ets_pkg::TimeWidth-1:0] t0,
                             input bit jitter);
      logic [9:0]                    levels;
      logic                          prev;
      logic [ets_pkg::TimeWidth-1:0] stamp;
      levels = {1'b1, data, 1'b0};
      prev   = 1'b1;
      for (int k = 0; k < 10; k++) begin
         if (levels[k] != prev) begin
            stamp = t0 + k * rx_period;
            if (jitter && rx_period > 3)
               stamp = stamp + $urandom_range(rx_period / 4);
            send_item(ets_pkg::CMD_EDGE, stamp, levels[k]);
            prev = levels[k];
         end
      end
   endtask

   task automatic close_frame(input logic [ets_pkg::TimeWidth-1:0] t0, input int mode);
      logic [ets_pkg::TimeWidth-1:0] expired;
      expired = t0 + rx_timeout + $urandom_range(20);
      case (mode)
         0: send_item(ets_pkg::CMD_TICK, expired, 1'b1);
         1: send_item(ets_pkg::CMD_TICK, expired, 1'b0);
         2: begin
            send_item(ets_pkg::CMD_TICK, t0 + $urandom_range(rx_timeout - 1), 1'b1);
            send_item(ets_pkg::CMD_TICK, expired, 1'b1);
         end
         default: ; // next start edge runs into this frame
      endcase
   endtask

   task automatic test_reset_defaults();
      send_item(ets_pkg::CMD_EDGE, 32'd500, 1'b1);     // idle, line high: ignored
      send_item(ets_pkg::CMD_TICK, 32'd600, 1'b1);     // nothing armed
      send_frame(8'h00, 32'd1000, 1'b0);               // stop edge completes it
      send_frame(8'hA5, 32'd3000, 1'b0);
      send_item(ets_pkg::CMD_TICK, 32'd3000 + rx_timeout, 1'b1);
      wait_idle();
   endtask

   task automatic test_special_cases();
      // stamp earlier than the previous edge counts by its distance
      send_item(ets_pkg::CMD_EDGE, 32'd5000, 1'b0);
      send_item(ets_pkg::CMD_EDGE, 32'd4700, 1'b1);
      send_item(ets_pkg::CMD_TICK, 32'd6000, 1'b1);
      // early tick, edge after expiry that completes the frame, then an unarmed line-low tick
      send_item(ets_pkg::CMD_EDGE, 32'd8000, 1'b0);
      send_item(ets_pkg::CMD_TICK, 32'd8999, 1'b1);
      send_item(ets_pkg::CMD_EDGE, 32'd9500, 1'b1);
      send_item(ets_pkg::CMD_TICK, 32'd9600, 1'b0);
      // timestamps wrapping through zero
      send_frame(8'hFF, 32'hFFFF_FF80, 1'b0);
      send_item(ets_pkg::CMD_TICK, 32'hFFFF_FF80 + rx_timeout, 1'b1);
      send_item(ets_pkg::CMD_EDGE, 32'hFFFF_FFFF, 1'b0);
      send_item(ets_pkg::CMD_EDGE, 32'h0000_0000, 1'b1);
      wait_idle();
   endtask

   task automatic test_zero_period();
      write_register(ets_pkg::CSR_BIT_PERIOD, 20'd0);
      send_item(ets_pkg::CMD_EDGE, 32'd100, 1'b0);
      send_item(ets_pkg::CMD_EDGE, 32'd100, 1'b0);
      send_item(ets_pkg::CMD_EDGE, 32'd200, 1'b0);
      send_item(ets_pkg::CMD_EDGE, 32'd250, 1'b1);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_register(ets_pkg::CSR_BIT_PERIOD, 20'd65535);
      write_register(ets_pkg::CSR_FRAME_TIMEOUT, 20'd1000000);
      send_frame(8'h5A, 32'h1000_0000, 1'b0);
      send_item(ets_pkg::CMD_TICK, 32'h1000_0000 + 32'd999999, 1'b1);
      send_item(ets_pkg::CMD_TICK, 32'h1000_0000 + 32'd1000000, 1'b1);
      wait_idle();
      write_register(ets_pkg::CSR_BIT_PERIOD, 20'd1);
      write_register(ets_pkg::CSR_FRAME_TIMEOUT, 20'd1);
      send_frame(8'hC3, 32'd50, 1'b0);
      send_item(ets_pkg::CMD_TICK, 32'd51, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_traffic(input logic [15:0] period, input logic [19:0] limit_us,
                                      input int n_items, input bit idling);
      int                            stop_at;
      logic [ets_pkg::TimeWidth-1:0] t_base;
      logic [ets_pkg::TimeWidth-1:0] span;
      write_register(ets_pkg::CSR_BIT_PERIOD, 20'(period));
      write_register(ets_pkg::CSR_FRAME_TIMEOUT, limit_us);
      idle_on = idling;
      stop_at = items_sent + n_items;
      t_base  = $urandom();
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 75) begin
            send_frame(8'($urandom_range(255)), t_base, $urandom_range(3) == 0);
            close_frame(t_base, $urandom_range(3));
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(ets_pkg::command_type'($urandom_range(1)),
                         $urandom_range(1) ? $urandom() : t_base + $urandom_range(16 * period),
                         $urandom_range(1));
         end
         span = 11 * period;
         if (32'(limit_us) > span)
            span = 32'(limit_us);
         t_base = t_base + span + $urandom_range(3 * period + 5);
         if ($urandom_range(19) == 0)
            t_base = $urandom();
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   // result side held off while frames keep coming, so the input stalls
   task automatic test_output_backpressure();
      logic [ets_pkg::TimeWidth-1:0] t0;
      write_register(ets_pkg::CSR_BIT_PERIOD, 20'd50);
      write_register(ets_pkg::CSR_FRAME_TIMEOUT, 20'd600);
      idle_on    = 1'b0;
      ready_hold = 400;
      t0         = $urandom();
      repeat (24) begin
         send_frame(8'($urandom_range(255)), t0, 1'b0);
         send_item(ets_pkg::CMD_TICK, t0 + 32'd600, 1'b1);
         t0 = t0 + 32'd700;
      end
      wait_idle();
      idle_on = 1'b1;
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      serial_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_data_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_data_byte !== want.data)
               report_mismatch($sformatf("data_byte %02h, expected %02h",
                                         rsp_data_byte, want.data));
            if (rsp_ended_by_timeout !== want.by_timeout)
               report_mismatch($sformatf("ended_by_timeout %b, expected %b",
                                         rsp_ended_by_timeout, want.by_timeout));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_command    = ets_pkg::CMD_EDGE;
      req_time_us    = '0;
      req_line_level = 1'b1;
      error_count    = 0;
      items_sent     = 0;
      bytes_checked  = 0;
      csr_writes     = 0;
      ready_hold     = 0;
      idle_on        = 1'b1;
      reset_receiver_model();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_zero_period();
      test_register_extremes();
      test_random_traffic(16'd100, 20'd1000, 250, 1'b1);
      test_random_traffic(16'd1, 20'd1, 200, 1'b1);
      test_random_traffic(16'd65535, 20'd1000000, 150, 1'b1);
      test_random_traffic(16'($urandom_range(2, 500)), 20'($urandom_range(1, 20000)), 250, 1'b1);
      test_random_traffic(16'd7, 20'd20000, 250, 1'b0);
      test_random_traffic(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1000000)),
                          250, 1'b1);
      test_output_backpressure();

      $display("Sent %0d items (edges and ticks) over %0d register writes; %0d bytes checked.",
               items_sent, csr_writes, bytes_checked);
      $display("Ran directed corner frames, zero and extreme periods, random framing and stall.");
      if (error_count == 0 && pending_bytes.size() == 0)
         $display("edge_timestamp_uart_receiver_core verification clean");
      else
         $display("edge_timestamp_uart_receiver_core verification failed");
      $finish;
   end

endmodule
